[hw/rtl/pse_pkg.sv]
// Package for the postfix stack evaluator: token and status codes,
// sequencer states and word constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pse_pkg;

    localparam int WORD_W              = 32;
    localparam int DEFAULT_STACK_DEPTH = 32;

    // Restoring divider takes one quotient bit per step
    localparam int DIV_STEPS = WORD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [WORD_W-1:0] MOST_NEG = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};
    localparam logic [WORD_W-1:0] WORD_ONE = {{(WORD_W-1){1'b0}}, 1'b1};

    typedef enum logic [2:0] {
        OP_PUSH   = 3'd0,
        OP_ADD    = 3'd1,
        OP_SUB    = 3'd2,
        OP_MUL    = 3'd3,
        OP_DIV    = 3'd4,
        OP_POW    = 3'd5,
        OP_MOD    = 3'd6,
        OP_FINISH = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        STAT_OK      = 3'd0,
        STAT_EMPTY   = 3'd1,
        STAT_DIVZERO = 3'd2,
        STAT_UNDER   = 3'd3,
        STAT_OVER    = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TOP,
        ST_SUB,
        ST_EXEC,
        ST_DIV,
        ST_DIV_END,
        ST_POW_MUL,
        ST_POW_SQ,
        ST_WB,
        ST_FIN
    } state_t;

endpackage : pse_pkg

`default_nettype wire

[hw/rtl/postfix_stack_evaluator.sv]
// Postfix stack evaluator: stack memory, sequencer and one shared
// multiplier / restoring divider. Depends on pse_pkg.
// Division and modulo run 32 divider steps; power runs two multiplier passes per
// exponent bit up to the top set bit; a negative exponent or zero divisor skips
// the loop. Busy: no s_ready.
// Reset (aresetn, synchronous, active low) clears state, count, error and result valid, not memory.
`timescale 1ns / 1ps
`default_nettype none

module postfix_stack_evaluator #(
    parameter int STACK_DEPTH = pse_pkg::DEFAULT_STACK_DEPTH
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_operation,
    input  wire logic signed [31:0] s_operand,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_value,
    output logic [2:0]              m_status
);

    import pse_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    // Stack memory
    logic [WORD_W-1:0] stack_mem [STACK_DEPTH];
    logic [WORD_W-1:0] rd_data_reg;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              wr_en;

    // Control and datapath registers
    state_t            state_reg, state_next;
    op_t               op_reg, op_next;
    logic [CW-1:0]     count_reg, count_next;
    status_t           err_reg, err_next;
    logic [WORD_W-1:0] top_reg, top_next;
    logic [WORD_W-1:0] sub_reg, sub_next;
    logic [WORD_W-1:0] result_reg, result_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [WORD_W-1:0] den_reg, den_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [WORD_W-1:0] sq_reg, sq_next;
    logic [WORD_W-1:0] exp_reg, exp_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic              m_valid_reg, m_valid_next;
    logic [WORD_W-1:0] m_value_reg, m_value_next;
    status_t           m_status_reg, m_status_next;

    // Shared multiplier and divider step
    logic [WORD_W-1:0] mul_a, mul_b, mul_prod;
    logic [WORD_W:0]   div_shift, div_diff;

    logic              s_xfer;
    op_t               s_op;
    logic              stack_full;
    logic              stack_empty;

    assign s_op        = op_t'(s_operation);
    assign stack_full  = (count_reg == CW'(STACK_DEPTH));
    assign stack_empty = (count_reg == '0);

    assign mul_prod  = mul_a * mul_b;
    assign div_shift = {rem_reg, quo_reg[WORD_W-1]};
    assign div_diff  = div_shift - {1'b0, den_reg};

    assign s_ready = (state_reg == ST_IDLE)
                   && ((s_op != OP_FINISH) || !m_valid_reg || m_ready);
    assign s_xfer  = s_valid && s_ready;

    assign m_valid  = m_valid_reg;
    assign m_value  = m_value_reg;
    assign m_status = m_status_reg;

    // Memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stack_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= stack_mem[rd_addr];
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            err_reg     <= STAT_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        top_reg      <= top_next;
        sub_reg      <= sub_next;
        result_reg   <= result_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        den_reg      <= den_next;
        acc_reg      <= acc_next;
        sq_reg       <= sq_next;
        exp_reg      <= exp_next;
        cnt_reg      <= cnt_next;
        m_value_reg  <= m_value_next;
        m_status_reg <= m_status_next;
    end

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        count_next    = count_reg;
        err_next      = err_reg;
        top_next      = top_reg;
        sub_next      = sub_reg;
        result_next   = result_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        den_next      = den_reg;
        acc_next      = acc_reg;
        sq_next       = sq_reg;
        exp_next      = exp_reg;
        cnt_next      = cnt_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_value_next  = m_value_reg;
        m_status_next = m_status_reg;
        rd_addr       = AW'(count_reg - CW'(1));
        wr_addr       = AW'(count_reg);
        wr_data       = result_reg;
        wr_en         = 1'b0;
        mul_a         = sub_reg;
        mul_b         = top_reg;

        case (state_reg)
            ST_IDLE: begin
                // top of stack is read at the transfer edge
                if (s_xfer) begin
                    op_next = s_op;
                    case (s_op)
                        OP_PUSH: begin
                            if (stack_full) begin
                                if (err_reg == STAT_OK) err_next = STAT_OVER;
                            end else begin
                                wr_en      = 1'b1;
                                wr_data    = s_operand;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_FINISH: state_next = ST_FIN;
                        default:   state_next = ST_TOP;
                    endcase
                end
            end

            ST_TOP: begin
                // pop top; subtop read issued now
                rd_addr = AW'(count_reg - CW'(2));
                if (stack_empty) begin
                    top_next = '0;
                    if (err_reg == STAT_OK) err_next = STAT_UNDER;
                end else begin
                    top_next   = rd_data_reg;
                    count_next = count_reg - CW'(1);
                end
                state_next = ST_SUB;
            end

            ST_SUB: begin
                if (stack_empty) begin
                    sub_next = '0;
                    if (err_reg == STAT_OK) err_next = STAT_UNDER;
                end else begin
                    sub_next   = rd_data_reg;
                    count_next = count_reg - CW'(1);
                end
                state_next = ST_EXEC;
            end

            ST_EXEC: begin
                state_next = ST_WB;
                case (op_reg)
                    OP_ADD: result_next = sub_reg + top_reg;
                    OP_SUB: result_next = sub_reg - top_reg;
                    OP_MUL: result_next = mul_prod;
                    OP_DIV, OP_MOD: begin
                        if (top_reg == '0) begin
                            result_next = MOST_NEG;
                            if (err_reg == STAT_OK) err_next = STAT_DIVZERO;
                        end else begin
                            rem_next   = '0;
                            quo_next   = sub_reg[WORD_W-1] ? (~sub_reg + WORD_ONE) : sub_reg;
                            den_next   = top_reg[WORD_W-1] ? (~top_reg + WORD_ONE) : top_reg;
                            cnt_next   = '0;
                            state_next = ST_DIV;
                        end
                    end
                    OP_POW: begin
                        if (top_reg[WORD_W-1]) begin
                            // negative exponent
                            if (sub_reg == WORD_ONE) begin
                                result_next = WORD_ONE;
                            end else if (sub_reg == ALL_ONES) begin
                                result_next = top_reg[0] ? ALL_ONES : WORD_ONE;
                            end else if (sub_reg == '0) begin
                                result_next = MOST_NEG;
                                if (err_reg == STAT_OK) err_next = STAT_DIVZERO;
                            end else begin
                                result_next = '0;
                            end
                        end else begin
                            acc_next   = WORD_ONE;
                            sq_next    = sub_reg;
                            exp_next   = top_reg;
                            state_next = ST_POW_MUL;
                        end
                    end
                    default: result_next = '0;
                endcase
            end

            ST_DIV: begin
                // one restoring step on magnitudes
                if (!div_diff[WORD_W]) begin
                    rem_next = div_diff[WORD_W-1:0];
                    quo_next = {quo_reg[WORD_W-2:0], 1'b1};
                end else begin
                    rem_next = div_shift[WORD_W-1:0];
                    quo_next = {quo_reg[WORD_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_DIV_END;
                end
            end

            ST_DIV_END: begin
                // quotient truncates to zero, remainder follows the dividend
                if (op_reg == OP_MOD) begin
                    result_next = sub_reg[WORD_W-1] ? (~rem_reg + WORD_ONE) : rem_reg;
                end else begin
                    result_next = (sub_reg[WORD_W-1] != top_reg[WORD_W-1])
                                ? (~quo_reg + WORD_ONE) : quo_reg;
                end
                state_next = ST_WB;
            end

            ST_POW_MUL: begin
                mul_a = acc_reg;
                mul_b = sq_reg;
                if (exp_reg == '0) begin
                    result_next = acc_reg;
                    state_next  = ST_WB;
                end else begin
                    if (exp_reg[0]) acc_next = mul_prod;
                    state_next = ST_POW_SQ;
                end
            end

            ST_POW_SQ: begin
                mul_a      = sq_reg;
                mul_b      = sq_reg;
                sq_next    = mul_prod;
                exp_next   = {1'b0, exp_reg[WORD_W-1:1]};
                state_next = ST_POW_MUL;
            end

            ST_WB: begin
                // two pops always leave room
                wr_en      = 1'b1;
                wr_data    = result_reg;
                count_next = count_reg + CW'(1);
                state_next = ST_IDLE;
            end

            ST_FIN: begin
                m_valid_next  = 1'b1;
                m_value_next  = stack_empty ? MOST_NEG : rd_data_reg;
                if (err_reg != STAT_OK) begin
                    m_status_next = err_reg;
                end else begin
                    m_status_next = stack_empty ? STAT_EMPTY : STAT_OK;
                end
                count_next = '0;
                err_next   = STAT_OK;
                state_next = ST_IDLE;
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_finish_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_operation == OP_FINISH)) |=> ##1 m_valid)
        else $error("finish transfer gave no result");

    a_finish_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN) |=> (count_reg == '0) && (err_reg == STAT_OK))
        else $error("finish did not clear stack and error");

    a_error_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        ((err_reg != STAT_OK) && (state_reg != ST_FIN)) |=> (err_reg == $past(err_reg)))
        else $error("sticky error overwritten");

endmodule : postfix_stack_evaluator

`default_nettype wire

[test/postfix_stack_evaluator_tb.sv]
// Self-checking testbench for postfix_stack_evaluator: drives token transfers with
// random gaps and back-pressure and checks every finish result against a shadow stack.
// Depends on pse_pkg and the postfix_stack_evaluator RTL.
`timescale 1ns / 1ps

module postfix_stack_evaluator_tb;
    import pse_pkg::*;

    localparam int          DEPTH        = DEFAULT_STACK_DEPTH;
    localparam int          RANDOM_ITEMS = 950;
    localparam int          DRAIN_CYCLES = 80;
    localparam int          MAX_REPORTS  = 10;
    localparam logic [31:0] MOST_POS     = 32'h7FFF_FFFF;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [2:0]         s_operation;
    logic signed [31:0] s_operand;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_value;
    logic [2:0]         m_status;

    // Shadow copy of the evaluator state
    logic [31:0] shadow_stack [0:DEPTH-1];
    int          shadow_count;
    status_t     shadow_err;

    // Expected finish results, oldest first
    logic [31:0] finish_value_q [$];
    status_t     finish_status_q [$];

    int  mismatch_count;
    int  tokens_sent;
    bit  tx_idle_en;
    bit  rx_idle_en;
    int  rx_hold;

    postfix_stack_evaluator DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_operand   (s_operand),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value     (m_value),
        .m_status    (m_status)
    );

    always #6 aclk = ~aclk;

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    function automatic logic [31:0] pick_operand();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return 32'($urandom_range(0, 16)) - 32'd8;
        if (r == 5) begin
            case ($urandom_range(0, 4))
                0: return MOST_NEG;
                1: return MOST_POS;
                2: return 32'd0;
                3: return ALL_ONES;
                default: return WORD_ONE;
            endcase
        end
        return $urandom;
    endfunction

    // ---------------- shadow stack ----------------

    function automatic void record_error(status_t code);
        if (shadow_err == STAT_OK) shadow_err = code;
    endfunction

    function automatic void push_shadow(logic [31:0] v);
        if (shadow_count < DEPTH) begin
            shadow_stack[shadow_count] = v;
            shadow_count++;
        end else begin
            record_error(STAT_OVER);
        end
    endfunction

    function automatic logic [31:0] pop_shadow();
        if (shadow_count == 0) begin
            record_error(STAT_UNDER);
            return 32'd0;
        end
        shadow_count--;
        return shadow_stack[shadow_count];
    endfunction

    // Signed divide truncating toward zero; remainder follows the dividend
    function automatic logic [31:0] divide_word(logic [31:0] a, logic [31:0] b, bit want_rem);
        logic [31:0] ma, mb, q, r;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q  = ma / mb;
        r  = ma % mb;
        if (want_rem) return a[31] ? -r : r;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic logic [31:0] power_word(logic [31:0] base, logic [31:0] ex);
        logic [31:0] acc, sq;
        acc = WORD_ONE;
        sq  = base;
        if (ex[31]) begin
            if (base == WORD_ONE) return WORD_ONE;
            if (base == ALL_ONES) return ex[0] ? ALL_ONES : WORD_ONE;
            if (base == 32'd0) begin
                record_error(STAT_DIVZERO);
                return MOST_NEG;
            end
            return 32'd0;
        end
        for (int i = 0; i < 31; i++) begin
            if (ex[i]) acc = acc * sq;
            sq = sq * sq;
        end
        return acc;
    endfunction

    // Advance the shadow state by one accepted token
    function automatic void eval_token(op_t op, logic [31:0] operand);
        logic [31:0] top, sub, res, val;
        status_t     st;
        case (op)
            OP_PUSH: push_shadow(operand);
            OP_FINISH: begin
                if (shadow_count == 0) begin
                    val = MOST_NEG;
                    st  = STAT_EMPTY;
                end else begin
                    val = shadow_stack[shadow_count-1];
                    st  = STAT_OK;
                end
                if (shadow_err != STAT_OK) st = shadow_err;
                finish_value_q.push_back(val);
                finish_status_q.push_back(st);
                shadow_count = 0;
                shadow_err   = STAT_OK;
            end
            default: begin
                top = pop_shadow();
                sub = pop_shadow();
                case (op)
                    OP_ADD: res = sub + top;
                    OP_SUB: res = sub - top;
                    OP_MUL: res = sub * top;
                    OP_DIV, OP_MOD: begin
                        if (top == 32'd0) begin
                            record_error(STAT_DIVZERO);
                            res = MOST_NEG;
                        end else begin
                            res = divide_word(sub, top, op == OP_MOD);
                        end
                    end
                    default: res = power_word(sub, top);
                endcase
                push_shadow(res);
            end
        endcase
    endfunction

    // ---------------- stimulus ----------------

    // Entered after a posedge; returns at the posedge the token transfer completes
    task automatic send_token(input op_t op, input logic [31:0] operand);
        int gap;
        gap = tx_idle_en ? pick_gap() : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_operand   <= operand;
        do @(posedge aclk); while (!s_ready);
        eval_token(op, operand);
        tokens_sent++;
    endtask

    task automatic send_binary(input logic [31:0] a, input logic [31:0] b, input op_t op);
        send_token(OP_PUSH, a);
        send_token(OP_PUSH, b);
        send_token(op, 32'd0);
    endtask

    // Finish on an empty stack
    task automatic test_empty_finish();
        send_token(OP_FINISH, pick_operand());
    endtask

    // Add and multiply wrapping past the word limits
    task automatic test_wrap_arith();
        send_binary(MOST_POS, WORD_ONE, OP_ADD);
        send_token(OP_PUSH, 32'd3);
        send_token(OP_MUL, 32'd0);
        send_token(OP_FINISH, 32'd0);
    endtask

    // Most negative over minus one, its modulo, and modulo by zero
    task automatic test_div_edges();
        send_binary(MOST_NEG, ALL_ONES, OP_DIV);
        send_token(OP_FINISH, 32'd0);
        send_binary(MOST_NEG, ALL_ONES, OP_MOD);
        send_token(OP_FINISH, 32'd0);
        send_binary(32'd7, 32'd0, OP_MOD);
        send_token(OP_FINISH, 32'd0);
    endtask

    // Zero raised to a negative power
    task automatic test_pow_zero_neg();
        send_binary(32'd0, -32'sd3, OP_POW);
        send_token(OP_FINISH, 32'd0);
    endtask

    // Operator on an empty stack
    task automatic test_underflow();
        send_token(OP_SUB, ALL_ONES);
        send_token(OP_FINISH, 32'd0);
    endtask

    // Well-formed expression with random operands and operators
    task automatic send_expression(input int n_operands);
        int depth, pushed;
        depth  = 0;
        pushed = 0;
        while (pushed < n_operands || depth > 1) begin
            if (pushed < n_operands && (depth < 2 || $urandom_range(0, 1) == 1)) begin
                send_token(OP_PUSH, pick_operand());
                depth++;
                pushed++;
            end else begin
                send_token(op_t'($urandom_range(OP_ADD, OP_MOD)), $urandom);
                depth--;
            end
        end
        send_token(OP_FINISH, $urandom);
    endtask

    // Fill to around the stack limit so that overflow turns up
    task automatic send_deep_fill();
        int n;
        n = $urandom_range(DEPTH - 4, DEPTH + 4);
        repeat (n) send_token(OP_PUSH, pick_operand());
        repeat ($urandom_range(0, 5)) send_token(op_t'($urandom_range(OP_ADD, OP_MOD)), $urandom);
        send_token(OP_FINISH, $urandom);
    endtask

    task automatic test_random_mix();
        int kind, limit, mode;
        limit = tokens_sent + RANDOM_ITEMS;
        while (tokens_sent < limit) begin
            // Change idling pattern now and then, including stretches with none
            if ($urandom_range(0, 11) == 0) begin
                mode       = $urandom_range(0, 3);
                tx_idle_en = mode[0];
                rx_idle_en = mode[1];
            end
            kind = $urandom_range(0, 99);
            if (kind < 72) begin
                send_expression($urandom_range(1, 8));
            end else if (kind < 80) begin
                send_deep_fill();
            end else begin
                repeat ($urandom_range(1, 10))
                    send_token(op_t'($urandom_range(OP_PUSH, OP_FINISH)), pick_operand());
            end
        end
        // Close on a finish so that the shadow state is fully checked
        send_token(OP_FINISH, 32'd0);
    endtask

    // ---------------- result side ----------------

    // Random back-pressure on the result channel
    always @(negedge aclk) begin
        if (aresetn) begin
            if (rx_hold > 0) begin
                m_ready <= 1'b0;
                rx_hold--;
            end else begin
                m_ready <= 1'b1;
                if (rx_idle_en && $urandom_range(0, 3) == 0) rx_hold = pick_gap();
            end
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                   input logic [31:0] act_v);
        if (mismatch_count < MAX_REPORTS)
            $display("[%0t] mismatch on %s: expected %0d (0x%08h), got %0d (0x%08h)",
                     $realtime, what, $signed(exp_v), exp_v, $signed(act_v), act_v);
        mismatch_count++;
    endtask

    // Check each result transfer against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (finish_value_q.size() == 0) begin
                report_mismatch("unexpected result value", 32'd0, m_value);
            end else begin
                if (m_value !== finish_value_q[0])
                    report_mismatch("value", finish_value_q[0], m_value);
                if (m_status !== finish_status_q[0])
                    report_mismatch("status", 32'(finish_status_q[0]), 32'(m_status));
                void'(finish_value_q.pop_front());
                void'(finish_status_q.pop_front());
            end
        end
    end

    // ---------------- sequence ----------------

    initial begin
        int waited;
        aclk           = 1'b0;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_operation    = OP_PUSH;
        s_operand      = '0;
        m_ready        = 1'b0;
        rx_hold        = 0;
        shadow_count   = 0;
        shadow_err     = STAT_OK;
        mismatch_count = 0;
        tokens_sent    = 0;
        tx_idle_en     = 1'b1;
        rx_idle_en     = 1'b1;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_finish();
        test_wrap_arith();
        test_div_edges();
        test_pow_zero_neg();
        test_underflow();
        test_random_mix();

        @(negedge aclk);
        s_valid <= 1'b0;

        // Drain outstanding results, then let the block settle
        waited = 0;
        while (finish_value_q.size() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && finish_value_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #15_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

[files.f]
hw/rtl/pse_pkg.sv
hw/rtl/postfix_stack_evaluator.sv
test/postfix_stack_evaluator_tb.sv
